/* rtl/core/pms_pkg.sv */
// ----------------------------------------------------------------------------
// pms_pkg
// Shared constants, codes and store port types for the prefix max search core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pms_pkg;

  // sizing
  localparam int DEPTH       = 1024;
  localparam int HEIGHT_BITS = 32;
  localparam int VALUE_W     = 32;
  localparam int SUM_W       = 42;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ADDR_W      = $clog2(DEPTH);

  // request codes
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // store write and read control
  typedef struct packed {
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [HEIGHT_BITS-1:0] wr_max;
    logic [SUM_W-1:0]       wr_sum;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
  } store_req_t;

  // registered read data
  typedef struct packed {
    logic [HEIGHT_BITS-1:0] max_val;
    logic [SUM_W-1:0]       sum_val;
  } store_rsp_t;

endpackage

/* rtl/core/pms_req_if.sv */
// ----------------------------------------------------------------------------
// pms_req_if
// Request channel: valid/ready handshake with request type and value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pms_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [pms_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

/* rtl/core/pms_rsp_if.sv */
// ----------------------------------------------------------------------------
// pms_rsp_if
// Result channel: valid/ready handshake with prefix sum and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pms_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [pms_pkg::SUM_W-1:0]  sum_result;
  logic [1:0]                 status;

  modport source (output valid, output sum_result, output status, input ready);
  modport sink   (input valid, input sum_result, input status, output ready);
endinterface

/* rtl/core/pms_store.sv */
// ----------------------------------------------------------------------------
// pms_store
// Prefix maximum and prefix sum memories, one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pms_store (
  input  logic                 clk,
  input  pms_pkg::store_req_t  ctl,
  output pms_pkg::store_rsp_t  rdata
);

  logic [pms_pkg::HEIGHT_BITS-1:0] max_mem [pms_pkg::DEPTH];
  logic [pms_pkg::SUM_W-1:0]       sum_mem [pms_pkg::DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      max_mem[ctl.wr_addr] <= ctl.wr_max;
      sum_mem[ctl.wr_addr] <= ctl.wr_sum;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata.max_val <= max_mem[ctl.rd_addr];
      rdata.sum_val <= sum_mem[ctl.rd_addr];
    end
  end

endmodule

/* rtl/core/prefix_max_search_prefix_sum_core.sv */
// ----------------------------------------------------------------------------
// prefix_max_search_prefix_sum_core
// Loads heights, keeps prefix max and prefix sum per element, and answers
// threshold queries by binary search over the prefix maxima.
// ----------------------------------------------------------------------------
// start and append go from the input transfer through S_EXEC and S_DONE to the
// output register. a query adds S_SEARCH, one state visit per search step, and
// S_SUM_WAIT when it reads a stored prefix sum; S_DONE waits for a free output.
// one search step per cycle, bounded by the single registered memory read.
// one item at a time; input is ready only while the sequencer is idle.
// rst (synchronous) empties the set; memory contents are not cleared.
`timescale 1ns / 1ps

module prefix_max_search_prefix_sum_core (
  input  logic       clk,
  input  logic       rst,
  pms_req_if.sink    req,
  pms_rsp_if.source  rsp
);

  localparam int CW = pms_pkg::CNT_W;
  localparam int AW = pms_pkg::ADDR_W;
  localparam int HW = pms_pkg::HEIGHT_BITS;
  localparam int SW = pms_pkg::SUM_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_SEARCH   = 3'd2;
  localparam logic [2:0] S_SUM_WAIT = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0]    state, state_next;
  logic [CW-1:0] elem_count, elem_count_next;
  logic [SW-1:0] running_sum, running_sum_next;
  logic [HW-1:0] running_max, running_max_next;

  // latched request
  logic [1:0]    op;
  logic [HW-1:0] arg;

  // search bounds and probe
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [AW-1:0] mid, mid_next;

  // pending result
  logic [SW-1:0] res_sum, res_sum_next;
  logic [1:0]    res_status, res_status_next;

  logic          out_valid;
  logic [SW-1:0] out_sum;
  logic [1:0]    out_status;

  pms_pkg::store_req_t st_ctl;
  pms_pkg::store_rsp_t st_rd;

  pms_store u_store (
    .clk   (clk),
    .ctl   (st_ctl),
    .rdata (st_rd)
  );

  // handshake
  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.sum_result = out_sum;
  assign rsp.status     = out_status;

  // saturating append sum and new running max
  logic [SW:0]   add_wide;
  logic [SW-1:0] add_sat;
  logic [HW-1:0] max_upd;
  assign add_wide = {1'b0, running_sum} + {{(SW + 1 - HW){1'b0}}, arg};
  assign add_sat  = add_wide[SW] ? {SW{1'b1}} : add_wide[SW-1:0];
  assign max_upd  = (arg > running_max) ? arg : running_max;

  // search step from the probe just read
  logic          probe_gt;
  logic [CW-1:0] step_lo, step_hi, step_span, step_mid;
  assign probe_gt  = st_rd.max_val > arg;
  assign step_lo   = probe_gt ? lo : ({1'b0, mid} + CW'(1));
  assign step_hi   = probe_gt ? {1'b0, mid} : hi;
  assign step_span = step_hi - step_lo;
  assign step_mid  = step_lo + (step_span >> 1);

  logic [CW-1:0] idx_m1;
  assign idx_m1 = step_lo - CW'(1);

  // sequencer
  always_comb begin
    state_next       = state;
    elem_count_next  = elem_count;
    running_sum_next = running_sum;
    running_max_next = running_max;
    lo_next          = lo;
    hi_next          = hi;
    mid_next         = mid;
    res_sum_next     = res_sum;
    res_status_next  = res_status;
    st_ctl           = '0;
    st_ctl.wr_addr   = elem_count[AW-1:0];
    st_ctl.wr_max    = max_upd;
    st_ctl.wr_sum    = add_sat;
    st_ctl.rd_addr   = mid;

    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        res_sum_next    = '0;
        res_status_next = pms_pkg::STATUS_OK;
        state_next      = S_DONE;
        case (op)
          pms_pkg::REQ_START: begin
            elem_count_next  = '0;
            running_sum_next = '0;
            running_max_next = '0;
          end
          pms_pkg::REQ_APPEND: begin
            if (elem_count == CW'(pms_pkg::DEPTH)) begin
              res_status_next = pms_pkg::STATUS_FULL;
            end else begin
              st_ctl.wr_en     = 1'b1;
              running_sum_next = add_sat;
              running_max_next = max_upd;
              elem_count_next  = elem_count + CW'(1);
            end
          end
          pms_pkg::REQ_QUERY: begin
            if (elem_count == '0) begin
              res_status_next = pms_pkg::STATUS_EMPTY;
            end else begin
              // first probe in the middle of [0, count)
              lo_next        = '0;
              hi_next        = elem_count;
              mid_next       = AW'(elem_count >> 1);
              st_ctl.rd_en   = 1'b1;
              st_ctl.rd_addr = AW'(elem_count >> 1);
              state_next     = S_SEARCH;
            end
          end
          default: ;
        endcase
      end
      S_SEARCH: begin
        lo_next = step_lo;
        hi_next = step_hi;
        if (step_lo < step_hi) begin
          mid_next       = step_mid[AW-1:0];
          st_ctl.rd_en   = 1'b1;
          st_ctl.rd_addr = step_mid[AW-1:0];
        end else if (step_lo == elem_count) begin
          // nothing exceeds the threshold
          res_sum_next = running_sum;
          state_next   = S_DONE;
        end else if (step_lo == '0) begin
          res_sum_next = '0;
          state_next   = S_DONE;
        end else begin
          st_ctl.rd_en   = 1'b1;
          st_ctl.rd_addr = idx_m1[AW-1:0];
          state_next     = S_SUM_WAIT;
        end
      end
      S_SUM_WAIT: begin
        res_sum_next = st_rd.sum_val;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      elem_count  <= '0;
      running_sum <= '0;
      running_max <= '0;
    end else begin
      state       <= state_next;
      elem_count  <= elem_count_next;
      running_sum <= running_sum_next;
      running_max <= running_max_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op  <= req.req_type;
      arg <= req.value[HW-1:0];
    end
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    res_sum    <= res_sum_next;
    res_status <= res_status_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_sum    <= res_sum;
      out_status <= res_status;
    end
  end

endmodule

/* verif/prefix_max_search_prefix_sum_core_tb.sv */
// ----------------------------------------------------------------------------
// prefix_max_search_prefix_sum_core_tb
// Self-checking bench for the prefix max search core. Requests go in through
// the request channel; a bit-accurate predictor of the prefix max and prefix
// sum tables works out each answer at the input transfer. The result channel
// is compared field by field, in order, against those answers. Both channels
// idle and stall at random, and a long result hold-off, run twice, backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prefix_max_search_prefix_sum_core_tb;

  // request code the block ignores
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam int          RANDOM_ITEMS = 150;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 1500000;
  localparam logic [pms_pkg::SUM_W:0] SUM_CEIL = {1'b0, {pms_pkg::SUM_W{1'b1}}};

  typedef struct packed {
    logic [pms_pkg::SUM_W-1:0] sum;
    logic [1:0]                status;
  } answer_t;

  logic clk = 1'b0;
  logic rst;

  pms_req_if req_ch ();
  pms_rsp_if rsp_ch ();

  prefix_max_search_prefix_sum_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // mirror of the stored set
  int unsigned                     set_count;
  logic [pms_pkg::SUM_W-1:0]       set_total;
  logic [pms_pkg::HEIGHT_BITS-1:0] set_peak;
  logic [pms_pkg::HEIGHT_BITS-1:0] peak_store [pms_pkg::DEPTH];
  logic [pms_pkg::SUM_W-1:0]       total_store [pms_pkg::DEPTH];

  answer_t answer_q [$];
  answer_t want;

  int errors        = 0;
  int sent          = 0;
  int ignored_sent  = 0;
  int results_seen  = 0;
  int query_count   = 0;
  int full_drops    = 0;
  int empty_queries = 0;
  int cycle_count   = 0;

  // idling control, shared by sender and receiver
  logic gaps_on       = 1'b1;
  int   hold_requests = 0;
  int   hold_served   = 0;
  int   hold_left     = 0;
  int   stall_left    = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("prefix_max_search_prefix_sum_core: mismatch");
      $finish;
    end
  end

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // apply one request to the mirrored set and return its answer
  function automatic answer_t apply_request(input logic [1:0] kind,
                                            input logic [pms_pkg::VALUE_W-1:0] v);
    answer_t                         a;
    logic [pms_pkg::HEIGHT_BITS-1:0] h;
    logic [pms_pkg::SUM_W:0]         s;
    int unsigned                     lo;
    int unsigned                     hi;
    int unsigned                     mid;
    a.sum    = '0;
    a.status = pms_pkg::STATUS_OK;
    h        = v[pms_pkg::HEIGHT_BITS-1:0];
    case (kind)
      pms_pkg::REQ_START: begin
        set_count = 0;
        set_total = '0;
        set_peak  = '0;
      end
      pms_pkg::REQ_APPEND: begin
        if (set_count >= pms_pkg::DEPTH) begin
          a.status = pms_pkg::STATUS_FULL;
          full_drops++;
        end else begin
          s = {1'b0, set_total} + h;
          set_total = (s > SUM_CEIL) ? SUM_CEIL[pms_pkg::SUM_W-1:0]
                                     : s[pms_pkg::SUM_W-1:0];
          if (h > set_peak) set_peak = h;
          peak_store[set_count]  = set_peak;
          total_store[set_count] = set_total;
          set_count++;
        end
      end
      pms_pkg::REQ_QUERY: begin
        query_count++;
        if (set_count == 0) begin
          a.status = pms_pkg::STATUS_EMPTY;
          empty_queries++;
        end else begin
          // first index whose prefix max is above the threshold
          lo = 0;
          hi = set_count;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (peak_store[mid] > h) hi = mid;
            else lo = mid + 1;
          end
          if (lo >= set_count) a.sum = set_total;
          else if (lo == 0) a.sum = '0;
          else a.sum = total_store[lo - 1];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // one request transfer; the answer is queued at the transfer edge
  task automatic send_request(input logic [1:0] kind,
                              input logic [pms_pkg::VALUE_W-1:0] v);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value    <= v;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    answer_q.push_back(apply_request(kind, v));
    sent++;
    if (kind == REQ_UNKNOWN) ignored_sent++;
  endtask

  // threshold near the stored prefix maxima, or anywhere
  function automatic logic [pms_pkg::VALUE_W-1:0] pick_threshold();
    logic [pms_pkg::HEIGHT_BITS-1:0] p;
    if (set_count == 0) return $urandom();
    p = peak_store[$urandom_range(0, set_count - 1)];
    case ($urandom_range(0, 6))
      0: return p;
      1: return p - 1'b1;
      2: return p + 1'b1;
      3: return $urandom();
      4: return '0;
      5: return '1;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // height in one of several shapes
  function automatic logic [pms_pkg::VALUE_W-1:0] pick_height(input int shape);
    case (shape)
      0: return $urandom();
      1: return $urandom_range(0, 255);
      2: return set_peak + $urandom_range(0, 1 << 20);
      default: return 32'hFFFF_FF00 | $urandom_range(0, 255);
    endcase
  endfunction

  // receiver: random stalls, plus a long counted hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left = HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap();
      rsp_ch.ready <= (stall_left == 0);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // result check against the oldest answer
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (answer_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: sum %0d status %0d",
                 $time, rsp_ch.sum_result, rsp_ch.status);
      end else begin
        want = answer_q.pop_front();
        results_seen++;
        if (rsp_ch.sum_result !== want.sum) begin
          errors++;
          $display("%0t: sum_result expected %0d actual %0d",
                   $time, want.sum, rsp_ch.sum_result);
        end
        if (rsp_ch.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, rsp_ch.status);
        end
      end
    end
  end

  // edges of the fields, every request code, empty set, first element above
  task automatic test_directed();
    send_request(pms_pkg::REQ_QUERY, 32'd0);
    send_request(REQ_UNKNOWN, 32'hFFFF_FFFF);
    send_request(pms_pkg::REQ_START, 32'hFFFF_FFFF);
    send_request(pms_pkg::REQ_QUERY, 32'hFFFF_FFFF);
    send_request(pms_pkg::REQ_APPEND, 32'd0);
    send_request(pms_pkg::REQ_QUERY, 32'd0);
    send_request(pms_pkg::REQ_QUERY, 32'hFFFF_FFFF);
    send_request(pms_pkg::REQ_APPEND, 32'hFFFF_FFFF);
    send_request(pms_pkg::REQ_APPEND, 32'd5);
    send_request(pms_pkg::REQ_APPEND, 32'h8000_0000);
    send_request(pms_pkg::REQ_QUERY, 32'd0);
    send_request(pms_pkg::REQ_QUERY, 32'hFFFF_FFFE);
    send_request(pms_pkg::REQ_QUERY, 32'hFFFF_FFFF);
    send_request(REQ_UNKNOWN, 32'h5555_AAAA);
    send_request(pms_pkg::REQ_START, 32'd0);
    send_request(pms_pkg::REQ_APPEND, 32'd100);
    send_request(pms_pkg::REQ_APPEND, 32'd50);
    send_request(pms_pkg::REQ_APPEND, 32'd200);
    send_request(pms_pkg::REQ_QUERY, 32'd99);
    send_request(pms_pkg::REQ_QUERY, 32'd100);
    send_request(pms_pkg::REQ_QUERY, 32'd199);
    send_request(pms_pkg::REQ_QUERY, 32'd200);
    send_request(pms_pkg::REQ_QUERY, 32'hAAAA_5555);
  endtask

  // fill the table to capacity, append past it, query the full set, then restart and query the empty set
  task automatic test_full_table();
    int unsigned i;
    gaps_on <= 1'b0;
    send_request(pms_pkg::REQ_START, $urandom());
    for (i = 0; i < pms_pkg::DEPTH; i++) begin
      if (i % 64 == 63) send_request(pms_pkg::REQ_APPEND, $urandom());
      else send_request(pms_pkg::REQ_APPEND, $urandom_range(0, i * 32'd4000000));
      if (i % 128 == 127) send_request(pms_pkg::REQ_QUERY, pick_threshold());
    end
    send_request(pms_pkg::REQ_APPEND, 32'd0);
    send_request(pms_pkg::REQ_APPEND, 32'hFFFF_FFFF);
    send_request(pms_pkg::REQ_APPEND, $urandom());
    send_request(pms_pkg::REQ_QUERY, 32'd0);
    send_request(pms_pkg::REQ_QUERY, 32'hFFFF_FFFF);
    repeat (8) send_request(pms_pkg::REQ_QUERY, pick_threshold());
    send_request(pms_pkg::REQ_START, 32'd0);
    send_request(pms_pkg::REQ_QUERY, $urandom());
    gaps_on <= 1'b1;
  endtask

  // random sets: loads with queries mixed in, plus noise
  task automatic test_random();
    int base;
    int n;
    int shape;
    int r;
    base = sent - ignored_sent;
    while (sent - ignored_sent - base < RANDOM_ITEMS) begin
      gaps_on <= ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) != 0 || set_count > pms_pkg::DEPTH - 256)
        send_request(pms_pkg::REQ_START, $urandom());
      r = $urandom_range(0, 99);
      if (r < 80) n = $urandom_range(1, 16);
      else if (r < 95) n = $urandom_range(17, 64);
      else n = $urandom_range(65, 200);
      shape = $urandom_range(0, 3);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) send_request(pms_pkg::REQ_QUERY, pick_threshold());
        else send_request(pms_pkg::REQ_APPEND, pick_height(shape));
      end
      repeat ($urandom_range(1, 6)) send_request(pms_pkg::REQ_QUERY, pick_threshold());
      if ($urandom_range(0, 19) == 0) send_request(REQ_UNKNOWN, $urandom());
      if ($urandom_range(0, 29) == 0) begin
        send_request(pms_pkg::REQ_START, $urandom());
        send_request(pms_pkg::REQ_QUERY, $urandom());
      end
    end
    gaps_on <= 1'b1;
  endtask

  // long result hold-off while requests keep coming
  task automatic test_backpressure();
    gaps_on <= 1'b0;
    hold_requests <= hold_requests + 1;
    send_request(pms_pkg::REQ_START, 32'd0);
    repeat (6) send_request(pms_pkg::REQ_APPEND, $urandom());
    repeat (6) send_request(pms_pkg::REQ_QUERY, pick_threshold());
    gaps_on <= 1'b1;
  endtask

  // sequence
  initial begin
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= pms_pkg::REQ_START;
    req_ch.value    <= '0;
    set_count = 0;
    set_total = '0;
    set_peak  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_full_table();
    test_random();
    test_backpressure();

    req_ch.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (answer_q.size() != 0) begin
      errors += answer_q.size();
      $display("%0t: %0d results never arrived", $time, answer_q.size());
    end

    $display("covered %0d requests (%0d queries, %0d ignored codes), %0d results checked",
             sent, query_count, ignored_sent, results_seen);
    $display("full table drops %0d, empty-set queries %0d, errors %0d",
             full_drops, empty_queries, errors);
    if (errors == 0) begin
      $display("prefix_max_search_prefix_sum_core: match");
    end else begin
      $display("prefix_max_search_prefix_sum_core: mismatch");
    end
    $finish;
  end

endmodule

/* prefix_max_search_prefix_sum_core.f */
rtl/core/pms_pkg.sv
rtl/core/pms_req_if.sv
rtl/core/pms_rsp_if.sv
rtl/core/pms_store.sv
rtl/core/prefix_max_search_prefix_sum_core.sv
verif/prefix_max_search_prefix_sum_core_tb.sv
